### src/tps_pkg.sv
// Shared types, constants and helpers for the triangle plane splitter.
package tps_pkg;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] vec_t;

  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_BAD = 2'd3;

  typedef struct packed {
    vec_t       a;
    vec_t       b;
    vec_t       c;
    logic [1:0] ax;
    coord_t     plane;
    logic       split;
    logic       cpos;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIN,
    BK_EMIT
  } bk_state_t;

  function automatic logic [32:0] ext33(input coord_t v);
    ext33 = {v[31], v};
  endfunction

  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] n;
    n = -d;
    mag33 = d[32] ? n[31:0] : d[31:0];
  endfunction

endpackage

### src/tps_in_if.sv
// Input channel carrying one triangle, its split axis and plane coordinate.
interface tps_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_a_x;
  logic signed [31:0] vert_a_y;
  logic signed [31:0] vert_a_z;
  logic signed [31:0] vert_b_x;
  logic signed [31:0] vert_b_y;
  logic signed [31:0] vert_b_z;
  logic signed [31:0] vert_c_x;
  logic signed [31:0] vert_c_y;
  logic signed [31:0] vert_c_z;
  logic [1:0]         split_axis;
  logic signed [31:0] plane_coord;

  modport source(output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                 vert_c_x, vert_c_y, vert_c_z, split_axis, plane_coord, input ready);
  modport sink(input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z, split_axis, plane_coord, output ready);
endinterface

### src/tps_out_if.sv
// Result channel carrying one output triangle with its side and last flags.
interface tps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_a_x;
  logic signed [31:0] out_a_y;
  logic signed [31:0] out_a_z;
  logic signed [31:0] out_b_x;
  logic signed [31:0] out_b_y;
  logic signed [31:0] out_b_z;
  logic signed [31:0] out_c_x;
  logic signed [31:0] out_c_y;
  logic signed [31:0] out_c_z;
  logic               on_positive;
  logic               last_piece;

  modport source(output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                 out_c_x, out_c_y, out_c_z, on_positive, last_piece, input ready);
  modport sink(input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
               out_c_x, out_c_y, out_c_z, on_positive, last_piece, output ready);
endinterface

### src/tps_front.sv
// Front end: accepts triangles, classifies vertex sides and orders the vertices.
module tps_front import tps_pkg::*; (
  tps_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push,
  output job_t     job
);

  vec_t       v0, v1, v2;
  logic [1:0] ax;
  logic       s0, s1, s2;

  assign v0 = {in_ch.vert_a_z, in_ch.vert_a_y, in_ch.vert_a_x};
  assign v1 = {in_ch.vert_b_z, in_ch.vert_b_y, in_ch.vert_b_x};
  assign v2 = {in_ch.vert_c_z, in_ch.vert_c_y, in_ch.vert_c_x};
  assign ax = (in_ch.split_axis == AXIS_BAD) ? AXIS_Z : in_ch.split_axis;

  assign s0 = $signed(v0[ax]) >= $signed(in_ch.plane_coord);
  assign s1 = $signed(v1[ax]) >= $signed(in_ch.plane_coord);
  assign s2 = $signed(v2[ax]) >= $signed(in_ch.plane_coord);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    job.ax    = ax;
    job.plane = in_ch.plane_coord;
    job.split = !((s0 == s1) && (s1 == s2));
    if (s0 == s1) begin
      job.a = v0;
      job.b = v1;
      job.c = v2;
      job.cpos = s2;
    end else if (s1 == s2) begin
      job.a = v1;
      job.b = v2;
      job.c = v0;
      job.cpos = s0;
    end else begin
      job.a = v0;
      job.b = v2;
      job.c = v1;
      job.cpos = s1;
    end
  end

endmodule

### src/tps_queue.sv
// Short queue of classified jobs between the front and back ends.
module tps_queue import tps_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == PTR_LAST) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == PTR_LAST) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

### src/tps_back.sv
// Back end: computes edge crossings with a shared multiplier and divider and emits pieces.
module tps_back import tps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  job_t      q_job,
  output logic      pop,
  tps_out_if.source out_ch
);

  localparam logic [1:0] COMP_LAST  = 2'd2;
  localparam logic [1:0] PIECE_LAST = 2'd2;
  localparam logic [1:0] PIECE_MID  = 2'd1;
  localparam logic [4:0] STEP_LAST  = 5'd31;

  bk_state_t   state_r, state_nxt;
  job_t        job_r;
  vec_t        p_r, q_r;
  logic        edge_r;
  logic [1:0]  comp_r, piece_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, lo_r, den_r;
  logic        neg_r;
  logic        out_valid_r;
  vec_t        o0_r, o1_r, o2_r;
  logic        opos_r, olast_r;

  vec_t        s_vec;
  logic [32:0] d_num, d_den, d_m, t_div, t_sub;
  logic [63:0] prod;
  logic        ge;
  coord_t      res;
  logic        out_ld, last_now;
  vec_t        n0, n1, n2;
  logic        npos;

  assign s_vec = edge_r ? job_r.b : job_r.a;
  assign d_num = ext33(job_r.plane) - ext33(s_vec[job_r.ax]);
  assign d_den = ext33(job_r.c[job_r.ax]) - ext33(s_vec[job_r.ax]);
  assign d_m   = ext33(job_r.c[comp_r]) - ext33(s_vec[comp_r]);
  assign prod  = 64'(mag33(d_m)) * 64'(mag33(d_num));
  assign t_div = {rem_r, lo_r[31]};
  assign t_sub = t_div - {1'b0, den_r};
  assign ge    = t_div >= {1'b0, den_r};
  assign res   = neg_r ? s_vec[comp_r] - $signed(lo_r) : s_vec[comp_r] + $signed(lo_r);
  assign last_now = !job_r.split || (piece_r == PIECE_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) state_nxt = q_job.split ? BK_MUL : BK_EMIT;
      end
      BK_MUL: state_nxt = BK_DIV;
      BK_DIV: begin
        if (cnt_r == STEP_LAST) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (comp_r == COMP_LAST && edge_r) state_nxt = BK_EMIT;
        else state_nxt = BK_MUL;
      end
      BK_EMIT: begin
        if (out_ld && last_now) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    out_ld = 1'b0;
    case (state_r)
      BK_IDLE: pop = !q_stat.empty;
      BK_EMIT: out_ld = !out_valid_r || out_ch.ready;
      default: begin
        pop    = 1'b0;
        out_ld = 1'b0;
      end
    endcase
  end

  always_comb begin
    npos = job_r.cpos;
    n0   = job_r.a;
    n1   = job_r.b;
    n2   = job_r.c;
    if (job_r.split) begin
      if (piece_r == PIECE_LAST) begin
        n0   = job_r.a;
        n1   = q_r;
        n2   = job_r.b;
        npos = !job_r.cpos;
      end else if (piece_r == PIECE_MID) begin
        n0   = p_r;
        n1   = q_r;
        n2   = job_r.a;
        npos = !job_r.cpos;
      end else begin
        n0 = p_r;
        n1 = q_r;
        n2 = job_r.c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        job_r   <= q_job;
        edge_r  <= 1'b0;
        comp_r  <= '0;
        piece_r <= '0;
      end
      BK_MUL: begin
        rem_r <= prod[63:32];
        lo_r  <= prod[31:0];
        den_r <= mag33(d_den);
        neg_r <= (d_m[32] != d_num[32]) != d_den[32];
        cnt_r <= '0;
      end
      BK_DIV: begin
        rem_r <= ge ? t_sub[31:0] : t_div[31:0];
        lo_r  <= {lo_r[30:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      BK_FIN: begin
        if (edge_r) q_r[comp_r] <= res;
        else p_r[comp_r] <= res;
        if (comp_r == COMP_LAST) begin
          comp_r <= '0;
          edge_r <= 1'b1;
        end else begin
          comp_r <= comp_r + 1'b1;
        end
      end
      BK_EMIT: begin
        if (out_ld) begin
          o0_r    <= n0;
          o1_r    <= n1;
          o2_r    <= n2;
          opos_r  <= npos;
          olast_r <= last_now;
          piece_r <= piece_r + 1'b1;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_a_x     = o0_r[0];
  assign out_ch.out_a_y     = o0_r[1];
  assign out_ch.out_a_z     = o0_r[2];
  assign out_ch.out_b_x     = o1_r[0];
  assign out_ch.out_b_y     = o1_r[1];
  assign out_ch.out_b_z     = o1_r[2];
  assign out_ch.out_c_x     = o2_r[0];
  assign out_ch.out_c_y     = o2_r[1];
  assign out_ch.out_c_z     = o2_r[2];
  assign out_ch.on_positive = opos_r;
  assign out_ch.last_piece  = olast_r;

endmodule

### src/triangle_plane_splitter.sv
// Top level of the triangle splitter against an axis-aligned plane.
//
//   channel  direction  transfer
//   in_ch    sink       one triangle, split axis and plane coordinate
//   out_ch   source     one result triangle with side and last flags
//
// A triangle lying wholly on one side leaves the queue and is emitted directly as a single piece.
// A split triangle takes six crossing coordinates in turn through the single shared
// multiplier and divider in the back end, each a multiply, 32 restoring divide steps
// and a finishing step, and is then emitted as three pieces.
// Reset is synchronous and clears the queue, the back-end sequencer and the output valid.
// The front keeps accepting into the queue while the back end works or the output stalls, until the queue is full.
module triangle_plane_splitter import tps_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  tps_in_if.sink    in_ch,
  tps_out_if.source out_ch
);

  logic    push, pop;
  job_t    f_job, q_job;
  q_stat_t q_stat;

  tps_front u_front (
    .in_ch  (in_ch),
    .q_full (q_stat.full),
    .push   (push),
    .job    (f_job)
  );

  tps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (f_job),
    .pop      (pop),
    .pop_job  (q_job),
    .stat     (q_stat)
  );

  tps_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_job  (q_job),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("Queue popped while empty.");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty)) else $error("Queue reports full and empty together.");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("Transfer accepted into a full queue.");

endmodule

### tb/tb_top.sv
// Testbench for the triangle plane splitter: directed table, random triangles, self-checking.
module tb_top;
  import tps_pkg::*;

  typedef struct {
    coord_t v [3][3];
    logic [1:0] axis;
    coord_t plane;
  } tri_job_t;

  typedef struct {
    coord_t v [3][3];
    logic pos;
    logic last;
  } piece_t;

  logic clk;
  logic rst_n;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  bit timed_out = 1'b0;
  int idle_mode;
  piece_t piece_q [$];
  tri_job_t job_tab [$];
  piece_t tab_piece [$];
  bit tab_has [$];

  tps_in_if in_ch();
  tps_out_if out_ch();

  triangle_plane_splitter u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Crossing of the edge from s to c with the plane, exact with truncating division.
  function automatic void edge_cross(input coord_t s[3], input coord_t c[3], input int ax,
                                     input coord_t plane, output coord_t p[3]);
    longint num;
    longint den;
    longint d;
    longint unsigned mn;
    longint unsigned md;
    longint unsigned mm;
    longint unsigned qq;
    bit neg;
    for (int k = 0; k < 3; k++) begin
      num = longint'(plane) - longint'(s[ax]);
      den = longint'(c[ax]) - longint'(s[ax]);
      d = longint'(c[k]) - longint'(s[k]);
      mn = (num < 0) ? longint'(-num) : num;
      md = (den < 0) ? longint'(-den) : den;
      mm = (d < 0) ? longint'(-d) : d;
      qq = (md != 0) ? (mm * mn) / md : 0;
      neg = ((d < 0) != (num < 0)) != (den < 0);
      p[k] = coord_t'(neg ? longint'(s[k]) - longint'(qq) : longint'(s[k]) + longint'(qq));
    end
  endfunction

  function automatic piece_t make_piece(input coord_t a[3], input coord_t b[3],
                                        input coord_t c[3], input logic pos, input logic last);
    piece_t r;
    for (int k = 0; k < 3; k++) begin
      r.v[0][k] = a[k];
      r.v[1][k] = b[k];
      r.v[2][k] = c[k];
    end
    r.pos = pos;
    r.last = last;
    return r;
  endfunction

  task automatic predict_split(input tri_job_t j);
    int ax;
    logic sd [3];
    coord_t va[3], vb[3], vc[3], p[3], q[3], w0[3], w1[3], w2[3];
    logic cpos;
    ax = (j.axis == AXIS_BAD) ? int'(AXIS_Z) : int'(j.axis);
    for (int i = 0; i < 3; i++) sd[i] = (j.v[i][ax] >= j.plane);
    for (int k = 0; k < 3; k++) begin
      w0[k] = j.v[0][k];
      w1[k] = j.v[1][k];
      w2[k] = j.v[2][k];
    end
    if (sd[0] == sd[1] && sd[1] == sd[2]) begin
      piece_q.insert(piece_q.size(), make_piece(w0, w1, w2, sd[0], 1'b1));
      return;
    end
    if (sd[0] == sd[1]) begin
      va = w0; vb = w1; vc = w2;
    end else if (sd[1] == sd[2]) begin
      va = w1; vb = w2; vc = w0;
    end else begin
      va = w0; vb = w2; vc = w1;
    end
    edge_cross(va, vc, ax, j.plane, p);
    edge_cross(vb, vc, ax, j.plane, q);
    cpos = (vc[ax] >= j.plane);
    piece_q.insert(piece_q.size(), make_piece(p, q, vc, cpos, 1'b0));
    piece_q.insert(piece_q.size(), make_piece(p, q, va, !cpos, 1'b0));
    piece_q.insert(piece_q.size(), make_piece(va, q, vb, !cpos, 1'b1));
  endtask

  function automatic coord_t rand_coord(input int style);
    case (style)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return coord_t'($urandom_range(0, 16)) - 32'sd8;
    endcase
  endfunction

  function automatic tri_job_t rand_job();
    tri_job_t j;
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        j.v[i][k] = rand_coord(($urandom_range(0, 9) == 0) ? 0 : style);
    j.axis = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) j.plane = rand_coord(style);
    else j.plane = j.v[$urandom_range(0, 2)][(j.axis == AXIS_BAD) ? 2 : j.axis]
                   + coord_t'($urandom_range(0, 2)) - 32'sd1;
    return j;
  endfunction

  function automatic tri_job_t fill_job(input coord_t val, input logic [1:0] axis,
                                        input coord_t plane);
    tri_job_t j;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) j.v[i][k] = val;
    j.axis = axis;
    j.plane = plane;
    return j;
  endfunction

  task automatic add_row(input tri_job_t j, input bit has, input piece_t p);
    job_tab.insert(job_tab.size(), j);
    tab_has.insert(tab_has.size(), has);
    tab_piece.insert(tab_piece.size(), p);
  endtask

  task automatic send_triangle(input tri_job_t j);
    while (idle_mode != 0 && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vert_a_x <= j.v[0][0]; in_ch.vert_a_y <= j.v[0][1]; in_ch.vert_a_z <= j.v[0][2];
    in_ch.vert_b_x <= j.v[1][0]; in_ch.vert_b_y <= j.v[1][1]; in_ch.vert_b_z <= j.v[1][2];
    in_ch.vert_c_x <= j.v[2][0]; in_ch.vert_c_y <= j.v[2][1]; in_ch.vert_c_z <= j.v[2][2];
    in_ch.split_axis <= j.axis;
    in_ch.plane_coord <= j.plane;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("Mismatch in %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  // Result side: random stalls while idle_mode is set, and field checks on every transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (piece_q.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 1);
        end else begin
          piece_t e;
          coord_t act [3][3];
          e = piece_q.pop_front();
          act = '{'{out_ch.out_a_x, out_ch.out_a_y, out_ch.out_a_z},
                  '{out_ch.out_b_x, out_ch.out_b_y, out_ch.out_b_z},
                  '{out_ch.out_c_x, out_ch.out_c_y, out_ch.out_c_z}};
          for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
              if (act[i][k] !== e.v[i][k])
                report_mismatch($sformatf("vertex %0d axis %0d", i, k), e.v[i][k], act[i][k]);
          if (out_ch.on_positive !== e.pos)
            report_mismatch("on_positive", e.pos, out_ch.on_positive);
          if (out_ch.last_piece !== e.last)
            report_mismatch("last_piece", e.last, out_ch.last_piece);
        end
      end
      out_ch.ready <= (idle_mode == 0) || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    tri_job_t j;
    piece_t p;
    int wait_cnt;
    idle_mode = 1;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.vert_a_x <= '0; in_ch.vert_a_y <= '0; in_ch.vert_a_z <= '0;
    in_ch.vert_b_x <= '0; in_ch.vert_b_y <= '0; in_ch.vert_b_z <= '0;
    in_ch.vert_c_x <= '0; in_ch.vert_c_y <= '0; in_ch.vert_c_z <= '0;
    in_ch.split_axis <= '0;
    in_ch.plane_coord <= '0;

    // Degenerate triangles at the extremes pass through unchanged.
    p = make_piece('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 1'b1, 1'b1);
    add_row(fill_job(32'sd0, 2'd0, 32'sd0), 1'b1, p);
    p = make_piece('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
                   '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
                   '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b1, 1'b1);
    add_row(fill_job(32'sh7fff_ffff, 2'd1, 32'sh8000_0000), 1'b1, p);
    p = make_piece('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
                   '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
                   '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, 1'b1);
    add_row(fill_job(32'sh8000_0000, AXIS_Z, 32'sh7fff_ffff), 1'b1, p);
    p = make_piece('{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, 1'b0, 1'b1);
    add_row(fill_job(-32'sd1, AXIS_BAD, 32'sd0), 1'b1, p);
    // Splits with each vertex alone, every axis including selector three, full range.
    for (int ax = 0; ax < 4; ax++)
      for (int lone = 0; lone < 3; lone++) begin
        j = fill_job(32'sh0001_0000, 2'(ax), 32'sd0);
        for (int i = 0; i < 3; i++)
          for (int k = 0; k < 3; k++)
            j.v[i][k] = coord_t'($urandom);
        for (int i = 0; i < 3; i++)
          j.v[i][(ax == 3) ? 2 : ax] = (i == lone) ? 32'sh7fff_ffff : 32'sh8000_0000;
        if (lone == 1) j.v[lone][(ax == 3) ? 2 : ax] = 32'sh8000_0000;
        if (lone == 1) j.v[0][(ax == 3) ? 2 : ax] = 32'sh7fff_ffff;
        if (lone == 1) j.v[2][(ax == 3) ? 2 : ax] = 32'sh7fff_ffff;
        add_row(j, 1'b0, p);
      end
    // Vertex exactly on the plane counts as positive.
    j = fill_job(32'sd0, 2'd0, 32'sd5);
    j.v[0][0] = 32'sd5; j.v[1][0] = 32'sd4; j.v[2][0] = 32'sd100; j.v[1][1] = -32'sd77;
    add_row(j, 1'b0, p);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < job_tab.size(); r++) begin
      if (tab_has[r]) piece_q.insert(piece_q.size(), tab_piece[r]);
      else predict_split(job_tab[r]);
      send_triangle(job_tab[r]);
    end
    in_ch.valid <= 1'b0;
    while (piece_q.size() != 0) @(posedge clk);

    for (int n = 0; n < 150; n++) begin
      if (n == 50) idle_mode = 0;
      if (n == 90) idle_mode = 1;
      if (n == 120) begin
        in_ch.valid <= 1'b0;
        while (piece_q.size() != 0) @(posedge clk);
      end
      j = rand_job();
      predict_split(j);
      send_triangle(j);
    end
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (piece_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (300) @(posedge clk);
    if (mismatch_cnt == 0 && piece_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### files.f
src/tps_pkg.sv
src/tps_in_if.sv
src/tps_out_if.sv
src/tps_front.sv
src/tps_queue.sv
src/tps_back.sv
src/triangle_plane_splitter.sv
tb/tb_top.sv
